>>> sv/dbia_pkg.sv
// Package: shared constants, types and digit helpers for the decimal ALU.
package dbia_pkg;

   localparam int DIGITS_DEFAULT = 40;
   localparam int MAX_DIGITS = 48;
   localparam int FIELD_DIGITS = 40;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_ADDSUB,
      ST_MUL,
      ST_DIV_SHIFT,
      ST_DIV_TRY,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic cmp_step;
      logic as_step;
      logic mul_step;
      logic div_shift;
      logic div_try;
      logic set_dz;
      logic clear_result;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic cmp_last;
      logic seq_last;
      logic b_zero;
      logic rem_ge_b;
      logic q_nine;
   } status_type;

   // Clamp a BCD nibble to a decimal digit.
   function automatic logic [3:0] clamp_digit(input logic [3:0] v);
      clamp_digit = (v > 4'd9) ? 4'd9 : v;
   endfunction

endpackage

>>> sv/dbia_if.sv
// Interfaces: valid/ready channels for request and response items.
interface dbia_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] a_low;
   logic [63:0] a_mid;
   logic [31:0] a_high;
   logic [63:0] b_low;
   logic [63:0] b_mid;
   logic [31:0] b_high;
   modport source (output valid, req_type, a_low, a_mid, a_high, b_low, b_mid, b_high,
                   input ready);
   modport sink (input valid, req_type, a_low, a_mid, a_high, b_low, b_mid, b_high,
                 output ready);
endinterface

interface dbia_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] r_low;
   logic [63:0] r_mid;
   logic [31:0] r_high;
   logic        a_equals_b;
   logic        a_below_b;
   logic        div_by_zero;
   modport source (output valid, r_low, r_mid, r_high, a_equals_b, a_below_b,
                   div_by_zero, input ready);
   modport sink (input valid, r_low, r_mid, r_high, a_equals_b, a_below_b,
                 div_by_zero, output ready);
endinterface

>>> sv/dbia_datapath.sv
// Datapath: digit registers, digit add/subtract, multiply and trial-subtract units, sequence counters.
module dbia_datapath #(
   parameter int DIGITS = dbia_pkg::DIGITS_DEFAULT
) (
   input  logic                  clock,
   input  dbia_pkg::cmd_type     cmd,
   output dbia_pkg::status_type  status,
   input  logic [1:0]            op,
   input  logic [63:0]           a_low,
   input  logic [63:0]           a_mid,
   input  logic [31:0]           a_high,
   input  logic [63:0]           b_low,
   input  logic [63:0]           b_mid,
   input  logic [31:0]           b_high,
   output logic [159:0]          result,
   output logic                  eq,
   output logic                  lt,
   output logic                  dz
);
   localparam int N = DIGITS;
   localparam int NR = DIGITS + 1;
   localparam int IW = $clog2(NR + 1);
   localparam int AW = (N > 1) ? $clog2(N) : 1;

   logic [159:0] a_raw, b_raw;
   logic [N-1:0][3:0] a_ff, b_ff, r_ff;
   logic [NR-1:0][3:0] rem_ff;
   logic [IW-1:0] i_ff, j_ff;
   logic carry_ff;
   logic [8:0] mcarry_ff;          // multiply column carry (column sum below 48*81 + carry)
   logic [11:0] acc_ff;            // running column sum
   logic [3:0] q_ff;
   logic cmp_done_ff, eq_ff, lt_ff, dz_ff;
   logic [IW-1:0] k_ff;            // digit index inside rem subtract
   logic sub_borrow_ff;
   logic try_busy_ff;

   assign a_raw = {a_high, a_mid, a_low};
   assign b_raw = {b_high, b_mid, b_low};

   // Compare rem with b over N+1 digits (combinational, decided by the highest differing digit).
   logic rem_ge;
   always_comb begin
      logic decided;
      decided = 1'b0;
      rem_ge = 1'b1;
      if (rem_ff[NR-1] != 4'd0) begin
         decided = 1'b1;
      end
      for (int x = N - 1; x >= 0; x--) begin
         if (!decided && rem_ff[x] != b_ff[x]) begin
            decided = 1'b1;
            rem_ge = rem_ff[x] > b_ff[x];
         end
      end
   end

   logic [IW-1:0] cmp_idx;
   assign cmp_idx = IW'(N - 1) - i_ff;

   // Multiply operand digits for column i, term j.
   logic [IW-1:0] ma_idx;
   logic [7:0] prod;
   assign ma_idx = i_ff - j_ff;
   assign prod = a_ff[ma_idx[AW-1:0]] * b_ff[j_ff[AW-1:0]];

   logic [4:0] as_sum;
   logic [3:0] as_dig;
   logic as_carry;
   always_comb begin
      logic [4:0] need;
      as_sum = '0;
      as_dig = '0;
      as_carry = 1'b0;
      need = '0;
      if (op == dbia_pkg::OP_ADD) begin
         as_sum = {1'b0, a_ff[i_ff[AW-1:0]]} + {1'b0, b_ff[i_ff[AW-1:0]]}
                  + {4'd0, carry_ff};
         as_carry = as_sum > 5'd9;
         as_dig = as_carry ? 4'(as_sum - 5'd10) : as_sum[3:0];
      end else begin
         need = {1'b0, b_ff[i_ff[AW-1:0]]} + {4'd0, carry_ff};
         as_carry = {1'b0, a_ff[i_ff[AW-1:0]]} < need;
         as_dig = 4'({1'b0, a_ff[i_ff[AW-1:0]]} + (as_carry ? 5'd10 : 5'd0) - need);
      end
   end

   // Closing column sum split into digit and carry: value below 8192 divided by 10.
   logic [12:0] col;
   logic [12:0] col_q;
   logic [3:0] col_d;
   assign col = {1'b0, acc_ff} + 13'(prod) + 13'(mcarry_ff);
   assign col_q = 13'((26'(col) * 26'd6554) >> 16);
   assign col_d = 4'(col - 13'(col_q * 13'd10));

   // Digit subtract for rem -= b, one digit per cycle.
   logic [3:0] sb_dig;
   logic sb_borrow;
   logic [3:0] sb_b;
   always_comb begin
      logic [4:0] need;
      sb_b = (k_ff < IW'(N)) ? b_ff[k_ff[AW-1:0]] : 4'd0;
      need = {1'b0, sb_b} + {4'd0, sub_borrow_ff};
      sb_borrow = {1'b0, rem_ff[k_ff[$clog2(NR)-1:0]]} < need;
      sb_dig = 4'({1'b0, rem_ff[k_ff[$clog2(NR)-1:0]]} + (sb_borrow ? 5'd10 : 5'd0) - need);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int x = 0; x < N; x++) begin
            if (x < dbia_pkg::FIELD_DIGITS) begin
               a_ff[x] <= dbia_pkg::clamp_digit(a_raw[x*4 +: 4]);
               b_ff[x] <= dbia_pkg::clamp_digit(b_raw[x*4 +: 4]);
            end else begin
               a_ff[x] <= '0;
               b_ff[x] <= '0;
            end
         end
         r_ff <= '0;
         rem_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         carry_ff <= 1'b0;
         mcarry_ff <= '0;
         acc_ff <= '0;
         q_ff <= '0;
         cmp_done_ff <= 1'b0;
         eq_ff <= 1'b1;
         lt_ff <= 1'b0;
         dz_ff <= 1'b0;
         k_ff <= '0;
         sub_borrow_ff <= 1'b0;
         try_busy_ff <= 1'b0;
      end
      // Compare from the top digit down, one digit a cycle.
      if (cmd.cmp_step) begin
         if (!cmp_done_ff && a_ff[cmp_idx[AW-1:0]] != b_ff[cmp_idx[AW-1:0]])
         begin
            cmp_done_ff <= 1'b1;
            eq_ff <= 1'b0;
            lt_ff <= a_ff[cmp_idx[AW-1:0]] < b_ff[cmp_idx[AW-1:0]];
         end
         i_ff <= (i_ff != IW'(N - 1)) ? i_ff + 1'b1
               : (op == dbia_pkg::OP_DIV) ? IW'(N - 1) : '0;
      end
      if (cmd.as_step) begin
         r_ff[i_ff[AW-1:0]] <= as_dig;
         carry_ff <= as_carry;
         i_ff <= i_ff + 1'b1;
      end
      // Multiply: accumulate one partial product a cycle, close a column on j == i.
      if (cmd.mul_step) begin
         if (j_ff == i_ff) begin
            r_ff[i_ff[AW-1:0]] <= col_d;
            mcarry_ff <= 9'(col_q);
            acc_ff <= '0;
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            acc_ff <= acc_ff + 12'(prod);
            j_ff <= j_ff + 1'b1;
         end
      end
      // Shift next dividend digit into the remainder.
      if (cmd.div_shift) begin
         for (int x = NR - 1; x > 0; x--) begin
            rem_ff[x] <= rem_ff[x-1];
         end
         rem_ff[0] <= a_ff[i_ff[AW-1:0]];
         q_ff <= '0;
         k_ff <= '0;
         sub_borrow_ff <= 1'b0;
         try_busy_ff <= 1'b0;
      end
      // Trial subtract: either start, step a digit, or write the quotient digit.
      if (cmd.div_try) begin
         if (!try_busy_ff) begin
            if (rem_ge && q_ff != 4'd9) begin
               try_busy_ff <= 1'b1;
               k_ff <= '0;
               sub_borrow_ff <= 1'b0;
            end else begin
               r_ff[i_ff[AW-1:0]] <= q_ff;
               i_ff <= i_ff - 1'b1;
            end
         end else begin
            rem_ff[k_ff[$clog2(NR)-1:0]] <= sb_dig;
            sub_borrow_ff <= sb_borrow;
            if (k_ff == IW'(NR - 1)) begin
               try_busy_ff <= 1'b0;
               q_ff <= q_ff + 1'b1;
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
      end
      if (cmd.set_dz) begin
         dz_ff <= 1'b1;
      end
      if (cmd.clear_result) begin
         r_ff <= '0;
      end
   end

   // Status to the controller.
   logic bz;
   always_comb begin
      bz = 1'b1;
      for (int x = 0; x < N; x++) begin
         if (b_ff[x] != 4'd0) begin
            bz = 1'b0;
         end
      end
   end

   // Trial status: busy counts as still subtracting; nine only when idle between trials.
   assign status.cmp_last = (i_ff == IW'(N - 1));
   assign status.b_zero = bz;
   assign status.rem_ge_b = try_busy_ff || rem_ge;
   assign status.q_nine = !try_busy_ff && (q_ff == 4'd9);
   assign status.seq_last = (op == dbia_pkg::OP_DIV)
                            ? (!try_busy_ff && !(rem_ge && q_ff != 4'd9) && i_ff == '0)
                            : (op == dbia_pkg::OP_MUL) ? (i_ff == IW'(N - 1) && j_ff == i_ff)
                            : (i_ff == IW'(N - 1));

   // Pack digits for the result fields; digits beyond the field width drop.
   always_comb begin
      result = '0;
      for (int x = 0; x < dbia_pkg::FIELD_DIGITS; x++) begin
         if (x < N) begin
            result[x*4 +: 4] = r_ff[x];
         end
      end
   end

   assign eq = eq_ff;
   assign lt = lt_ff;
   assign dz = dz_ff;
endmodule

>>> sv/dbia_control.sv
// Controller: sequences compare, add/subtract, multiply and divide steps.
module dbia_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   output logic [1:0]            op,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dbia_pkg::cmd_type     cmd,
   input  dbia_pkg::status_type  status
);
   dbia_pkg::state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;

   // Hold state and operation.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbia_pkg::ST_IDLE;
         op_ff <= dbia_pkg::OP_ADD;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         dbia_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in = req_op;
               state_in = dbia_pkg::ST_CMP;
            end
         end
         dbia_pkg::ST_CMP: begin
            cmd.cmp_step = 1'b1;
            if (status.cmp_last) begin
               case (op_ff)
                  dbia_pkg::OP_ADD, dbia_pkg::OP_SUB: state_in = dbia_pkg::ST_ADDSUB;
                  dbia_pkg::OP_MUL: state_in = dbia_pkg::ST_MUL;
                  default: begin
                     if (status.b_zero) begin
                        cmd.set_dz = 1'b1;
                        state_in = dbia_pkg::ST_DONE;
                     end else begin
                        state_in = dbia_pkg::ST_DIV_SHIFT;
                     end
                  end
               endcase
            end
         end
         dbia_pkg::ST_ADDSUB: begin
            cmd.as_step = 1'b1;
            if (status.seq_last) begin
               state_in = dbia_pkg::ST_DONE;
            end
         end
         dbia_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.seq_last) begin
               state_in = dbia_pkg::ST_DONE;
            end
         end
         dbia_pkg::ST_DIV_SHIFT: begin
            cmd.div_shift = 1'b1;
            state_in = dbia_pkg::ST_DIV_TRY;
         end
         // Stay while subtracting; move to the next digit once its quotient is written.
         dbia_pkg::ST_DIV_TRY: begin
            cmd.div_try = 1'b1;
            if (status.seq_last) begin
               state_in = dbia_pkg::ST_DONE;
            end else if (!status.rem_ge_b || status.q_nine) begin
               state_in = dbia_pkg::ST_DIV_SHIFT;
            end
         end
         dbia_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = dbia_pkg::ST_IDLE;
            end
         end
         default: state_in = dbia_pkg::ST_IDLE;
      endcase
   end

   assign op = op_ff;
endmodule

>>> sv/decimal_big_integer_alu.sv
// Top level: 40-digit decimal ALU with add, subtract, multiply and divide.
// Operation: a compare pass over the digits, then add/sub one digit at a time, multiply
// one partial product at a time, or divide by shift and trial subtract of the remainder,
// all sequenced step by step; the result is then held until it is handed off.
// One item at a time; the next is taken after the result is delivered.
// Reset (synchronous) returns the controller to idle; digit registers hold.
module decimal_big_integer_alu #(
   parameter int DIGITS = dbia_pkg::DIGITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   dbia_req_if.sink   req,
   dbia_rsp_if.source rsp
);
   dbia_pkg::cmd_type    cmd;
   dbia_pkg::status_type status;
   logic [1:0] op;
   logic [159:0] result;
   logic dp_eq, dp_lt, dp_dz;

   dbia_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_op(req.req_type),
      .op(op), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .status(status)
   );

   dbia_datapath #(.DIGITS(DIGITS)) u_datapath (
      .clock(clock), .cmd(cmd), .status(status), .op(op),
      .a_low(req.a_low), .a_mid(req.a_mid), .a_high(req.a_high),
      .b_low(req.b_low), .b_mid(req.b_mid), .b_high(req.b_high),
      .result(result), .eq(dp_eq), .lt(dp_lt), .dz(dp_dz)
   );

   assign rsp.r_low = result[63:0];
   assign rsp.r_mid = result[127:64];
   assign rsp.r_high = result[159:128];
   assign rsp.a_equals_b = dp_eq;
   assign rsp.a_below_b = dp_lt;
   assign rsp.div_by_zero = dp_dz;

`ifndef SYNTHESIS
   // Never take a new item while a result waits.
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("request taken while response pending");
   // Equal and below never both set on a result.
   assert property (@(posedge clock) disable iff (reset)
                    rsp.valid |-> !(rsp.a_equals_b && rsp.a_below_b))
      else $error("equal and below both set");
   // Divide by zero leaves a zero result.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp.valid && rsp.div_by_zero) |-> (rsp.r_low == 64'd0))
      else $error("nonzero result on divide by zero");
`endif
endmodule
